FILE: rtl/rbf_pkg.sv
// Shared types, constants and pipeline depths of the radial basis function unit.
package rbf_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned XW        = 24;
  localparam int unsigned BW        = 24;
  localparam int unsigned YW        = 40;

  // register stages inside each kernel; every kernel is padded to RBF_LAT
  localparam int unsigned GAUSS_LAT = 51;
  localparam int unsigned MQ_LAT    = 28;
  localparam int unsigned TPS_LAT   = 37;
  localparam int unsigned RBF_LAT   = GAUSS_LAT;

  localparam logic [32:0] Q32_ONE  = 33'h1_0000_0000;
  localparam logic [27:0] LN2_Q28  = 28'd186065279;
  localparam logic [YW-1:0] Y_POS_MAX = 40'h7F_FFFF_FFFF;
  localparam logic [YW-1:0] Y_NEG_MAG = 40'h80_0000_0000;

  typedef enum logic [1:0] {
    MODE_GAUSS  = 2'd0,
    MODE_MQUAD  = 2'd1,
    MODE_TPS    = 2'd2,
    MODE_BYPASS = 2'd3
  } rbf_mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_ZERO    = 2'd2,
    ST_SAT     = 2'd3
  } rbf_status_e;

  typedef enum logic {
    CFG_MODE = 1'b0,
    CFG_BETA = 1'b1
  } rbf_cfg_e;

  typedef struct packed {
    logic [YW-1:0] y;
    logic          sat;
  } rbf_res_t;

endpackage

FILE: rtl/rbf_gauss.sv
// Gaussian kernel exp(-beta*x*x): Horner series for exp(-beta*x*x/32), then five squarings.
module rbf_gauss import rbf_pkg::*; (
  input  logic          clk_i,
  input  logic [XW-1:0] xa_i,
  input  logic [BW-1:0] beta_i,
  output rbf_res_t      res_o
);

  localparam int unsigned TSh    = 3 * FRAC_BITS - 32;
  localparam int unsigned CapBit = 37 + TSh;

  logic [47:0] xx_q;
  logic [47:0] pl_q;
  logic [46:0] ph_q;
  logic [70:0] prod;

  logic [31:0] hf   [15];
  logic [32:0] he   [15];
  logic        hcap [15];
  logic [32:0] se   [5];
  logic        scap [5];
  logic [33:0] rnd;

  assign prod = 71'(pl_q) + (71'(ph_q) << 24);

  always_ff @(posedge clk_i) begin
    xx_q    <= 48'(xa_i) * 48'(xa_i);
    pl_q    <= 48'(xx_q[23:0]) * 48'(beta_i);
    ph_q    <= 47'(xx_q[46:24]) * 47'(beta_i);
    hf[0]   <= prod[CapBit-1 -: 32];
    he[0]   <= Q32_ONE;
    hcap[0] <= |prod[70:CapBit];
  end

  // one Horner term per three stages: multiply, reciprocal multiply, correct
  for (genvar i = 0; i < 14; i++) begin : g_horner
    localparam int unsigned Kd = 14 - i;
    localparam logic [32:0] Recip = 33'((65'd1 << 32) / Kd);

    logic [64:0] p;
    logic [31:0] q_a, f_a, q_b, f_b, qh, qd;
    logic        cap_a, cap_b;
    logic [64:0] est_b;
    logic [35:0] r;

    assign p  = 65'(hf[i]) * 65'(he[i]);
    assign qh = est_b[63:32];
    assign r  = 36'(q_b) - 36'(qh) * 36'(Kd);
    assign qd = qh + 32'(r >= 36'(Kd));

    always_ff @(posedge clk_i) begin
      q_a       <= p[63:32];
      f_a       <= hf[i];
      cap_a     <= hcap[i];
      est_b     <= 65'(q_a) * 65'(Recip);
      q_b       <= q_a;
      f_b       <= f_a;
      cap_b     <= cap_a;
      hf[i+1]   <= f_b;
      he[i+1]   <= Q32_ONE - {1'b0, qd};
      hcap[i+1] <= cap_b;
    end
  end

  for (genvar j = 0; j < 5; j++) begin : g_square
    logic [32:0] src;
    logic        src_cap;
    logic [64:0] sq;

    if (j == 0) begin : g_first
      assign src     = he[14];
      assign src_cap = hcap[14];
    end else begin : g_next
      assign src     = se[j-1];
      assign src_cap = scap[j-1];
    end

    assign sq = 65'(src[31:0]) * 65'(src[31:0]) + 65'h8000_0000;

    always_ff @(posedge clk_i) begin
      se[j]   <= (src < Q32_ONE) ? sq[64:32] : src;
      scap[j] <= src_cap;
    end
  end

  assign rnd = 34'(se[4]) + (34'd1 << (31 - FRAC_BITS));

  always_ff @(posedge clk_i) begin
    res_o.y   <= scap[4] ? '0 : YW'(rnd >> (32 - FRAC_BITS));
    res_o.sat <= 1'b0;
  end

endmodule

FILE: rtl/rbf_mquad.sv
// Multiquadratic kernel sqrt(x*x + beta*beta), one root bit per stage, rounded.
module rbf_mquad import rbf_pkg::*; (
  input  logic          clk_i,
  input  logic [XW-1:0] xa_i,
  input  logic [BW-1:0] beta_i,
  output rbf_res_t      res_o
);

  localparam int unsigned PadN = RBF_LAT - MQ_LAT + 1;

  logic [47:0] xx_q, bb_q;
  logic [48:0] sn [26];
  logic [49:0] sr [26];
  logic [49:0] r_rnd;
  rbf_res_t    pd [PadN];

  always_ff @(posedge clk_i) begin
    xx_q  <= 48'(xa_i) * 48'(xa_i);
    bb_q  <= 48'(beta_i) * 48'(beta_i);
    sn[0] <= 49'(xx_q) + 49'(bb_q);
    sr[0] <= '0;
  end

  for (genvar j = 0; j < 25; j++) begin : g_root
    localparam logic [49:0] Bit = 50'd1 << (2 * (24 - j));
    logic [49:0] trial;

    assign trial = sr[j] + Bit;

    always_ff @(posedge clk_i) begin
      if ({1'b0, sn[j]} >= trial) begin
        sn[j+1] <= sn[j] - trial[48:0];
        sr[j+1] <= (sr[j] >> 1) + Bit;
      end else begin
        sn[j+1] <= sn[j];
        sr[j+1] <= sr[j] >> 1;
      end
    end
  end

  // round to nearest: bump when the remainder exceeds the root
  assign r_rnd = sr[25] + 50'({1'b0, sn[25]} > sr[25]);

  always_ff @(posedge clk_i) begin
    pd[0].y   <= YW'(r_rnd);
    pd[0].sat <= 1'b0;
    for (int k = 1; k < PadN; k++) begin
      pd[k] <= pd[k-1];
    end
  end

  assign res_o = pd[PadN-1];

endmodule

FILE: rtl/rbf_tps.sv
// Thin plate spline kernel x*x*ln(x): log2 by repeated squaring, scale by ln2, saturate.
module rbf_tps import rbf_pkg::*; (
  input  logic          clk_i,
  input  logic [XW-1:0] x_i,
  output rbf_res_t      res_o
);

  localparam int unsigned PadN = RBF_LAT - TPS_LAT + 1;

  logic [4:0]  m_c;
  logic [53:0] zs;
  logic [30:0] tz  [31];
  logic [29:0] tf  [31];
  logic [4:0]  tm  [31];
  logic [45:0] txx [31];

  logic        neg_c;
  logic [34:0] mag_c;
  logic [34:0] mag_q;
  logic [62:0] pp_q;
  logic [63:0] pp_rnd;
  logic [34:0] lnm_q;
  logic [57:0] pl_q, ph_q;
  logic [80:0] sum_q;
  logic [45:0] xx32_q, xx33_q, xx34_q;
  logic        n32_q, n33_q, n34_q, n35_q, n36_q;
  logic [YW-1:0] qr, lim, ysat;
  logic          sat;
  rbf_res_t      pd [PadN];

  // leading one of the sample
  always_comb begin
    m_c = '0;
    for (int b = 0; b < XW - 1; b++) begin
      if (x_i[b]) m_c = 5'(b);
    end
  end

  assign zs = 54'(x_i[XW-2:0]) << (5'd30 - m_c);

  always_ff @(posedge clk_i) begin
    tz[0]  <= zs[30:0];
    tf[0]  <= '0;
    tm[0]  <= m_c;
    txx[0] <= 46'(x_i[XW-2:0]) * 46'(x_i[XW-2:0]);
  end

  // one fraction bit of log2 per stage
  for (genvar i = 0; i < 30; i++) begin : g_log
    localparam logic [29:0] FBit = 30'd1 << (29 - i);
    logic [61:0] p;

    assign p = 62'(tz[i]) * 62'(tz[i]);

    always_ff @(posedge clk_i) begin
      if (p[61]) begin
        tz[i+1] <= p[61:31];
        tf[i+1] <= tf[i] | FBit;
      end else begin
        tz[i+1] <= p[60:30];
        tf[i+1] <= tf[i];
      end
      tm[i+1]  <= tm[i];
      txx[i+1] <= txx[i];
    end
  end

  assign neg_c = tm[30] < 5'(FRAC_BITS);
  assign mag_c = neg_c ? ({5'(5'(FRAC_BITS) - tm[30]), 30'd0} - {5'd0, tf[30]})
                       : {5'(tm[30] - 5'(FRAC_BITS)), tf[30]};
  assign pp_rnd = 64'(pp_q) + (64'd1 << 27);

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_c;
    n32_q  <= neg_c;
    xx32_q <= txx[30];
    pp_q   <= 63'(mag_q) * 63'(LN2_Q28);
    n33_q  <= n32_q;
    xx33_q <= xx32_q;
    lnm_q  <= pp_rnd[62:28];
    n34_q  <= n33_q;
    xx34_q <= xx33_q;
    pl_q   <= 58'(xx34_q[22:0]) * 58'(lnm_q);
    ph_q   <= 58'(xx34_q[45:23]) * 58'(lnm_q);
    n35_q  <= n34_q;
    sum_q  <= 81'(pl_q) + (81'(ph_q) << 23);
    n36_q  <= n35_q;
  end

  assign qr   = 40'(sum_q[80:FRAC_BITS+30]) + 40'(sum_q[FRAC_BITS+29]);
  assign lim  = n36_q ? Y_NEG_MAG : Y_POS_MAX;
  assign sat  = qr > lim;
  assign ysat = sat ? lim : qr;

  always_ff @(posedge clk_i) begin
    pd[0].y   <= n36_q ? (40'd0 - ysat) : ysat;
    pd[0].sat <= sat;
    for (int k = 1; k < PadN; k++) begin
      pd[k] <= pd[k-1];
    end
  end

  assign res_o = pd[PadN-1];

endmodule

FILE: rtl/radial_basis_function_unit.sv
// Top level of the radial basis function unit: config, input stage, kernels, result stage.
//
// Usage:
//   Request channel: drive x_value_i (signed Q8.16) with start high; the request
//   is taken at a rising edge where start is high and busy is low. busy stays
//   low, so one request can be taken every cycle.
//   Result channel: valid_o strobes for one cycle with y_value_o (signed Q24.16)
//   and status_o (0 ok, 1 invalid, 2 zero, 3 saturated). The receiver cannot
//   hold results off; results leave in request order.
//   Pipeline: the accepting edge loads one input stage, then 51 kernel stages set by
//   the Gaussian kernel (a Horner chain of three stages per term, then squarings),
//   then one result stage drives valid_o. Throughput: one request per cycle.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i
//   (0 mode, 1 beta) at the clock edge; write only while no request is in flight.
//   Reset: rst_ni clears all in-flight requests, sets mode to Gaussian and
//   beta to 1.0. No clearing pass follows reset.
module radial_basis_function_unit import rbf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [XW-1:0]        x_value_i,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_index_i,
  input  logic [BW-1:0]        cfg_data_i,
  output logic                 valid_o,
  output logic signed [YW-1:0] y_value_o,
  output logic [1:0]           status_o
);

  rbf_mode_e   mode_q;
  logic [BW-1:0] beta_q;

  logic          accept;
  logic          v0_q;
  logic [XW-1:0] raw0_q, xa0_q;
  logic          inv0_q;
  logic [XW-1:0] xneg;

  logic          vld_q [RBF_LAT];
  logic [XW-1:0] raw_q [RBF_LAT];
  logic          inv_q [RBF_LAT];

  rbf_res_t gauss_res, mquad_res, tps_res, sel_res;
  logic [YW-1:0] y_d;
  rbf_status_e   st_d;

  // never stalls: every request gets a slot in the pipeline
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_GAUSS;
      beta_q <= BW'(1 << FRAC_BITS);
    end else if (cfg_we_i) begin
      unique case (rbf_cfg_e'(cfg_index_i))
        CFG_MODE: mode_q <= rbf_mode_e'(cfg_data_i[1:0]);
        CFG_BETA: beta_q <= cfg_data_i;
        default:  mode_q <= mode_q;
      endcase
    end
  end

  // input stage: take the magnitude; two's complement of the most negative
  // sample gives back the same pattern, which is its magnitude
  assign xneg = XW'(0) - x_value_i;

  always_ff @(posedge clk_i) begin
    raw0_q <= x_value_i;
    xa0_q  <= x_value_i[XW-1] ? xneg : x_value_i;
    inv0_q <= x_value_i[XW-1] || (x_value_i == '0);
  end

  // valid bits travel alongside the kernels, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      for (int k = 0; k < RBF_LAT; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      v0_q     <= accept;
      vld_q[0] <= v0_q;
      for (int k = 1; k < RBF_LAT; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // hold the raw sample and the log-domain flag for bypass and invalid cases
  always_ff @(posedge clk_i) begin
    raw_q[0] <= raw0_q;
    inv_q[0] <= inv0_q;
    for (int k = 1; k < RBF_LAT; k++) begin
      raw_q[k] <= raw_q[k-1];
      inv_q[k] <= inv_q[k-1];
    end
  end

  // all three kernels run on every sample; the mode picks one, or the raw sample for bypass, at the end
  rbf_gauss u_gauss (
    .clk_i  (clk_i),
    .xa_i   (xa0_q),
    .beta_i (beta_q),
    .res_o  (gauss_res)
  );

  rbf_mquad u_mquad (
    .clk_i  (clk_i),
    .xa_i   (xa0_q),
    .beta_i (beta_q),
    .res_o  (mquad_res)
  );

  rbf_tps u_tps (
    .clk_i (clk_i),
    .x_i   (raw0_q),
    .res_o (tps_res)
  );

  always_comb begin
    sel_res = gauss_res;
    unique case (mode_q)
      MODE_GAUSS:  sel_res = gauss_res;
      MODE_MQUAD:  sel_res = mquad_res;
      MODE_TPS:    sel_res = tps_res;
      MODE_BYPASS: begin
        sel_res.y   = {{(YW - XW){raw_q[RBF_LAT-1][XW-1]}}, raw_q[RBF_LAT-1]};
        sel_res.sat = 1'b0;
      end
      default:     sel_res = gauss_res;
    endcase
  end

  // status: bypass is always ok; drop the log of a non-positive sample to zero as invalid; else saturated, zero or ok
  always_comb begin
    y_d  = sel_res.y;
    st_d = ST_OK;
    priority if (mode_q == MODE_BYPASS) begin
      st_d = ST_OK;
    end else if (mode_q == MODE_TPS && inv_q[RBF_LAT-1]) begin
      y_d  = '0;
      st_d = ST_INVALID;
    end else if (sel_res.sat) begin
      st_d = ST_SAT;
    end else if (sel_res.y == '0) begin
      st_d = ST_ZERO;
    end else begin
      st_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= vld_q[RBF_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    y_value_o <= y_d;
    status_o  <= st_d;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##53 valid_o)
    else $error("request did not come out after the pipeline latency");

  a_invalid_tps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == ST_INVALID) |-> (mode_q == MODE_TPS && y_value_o == '0))
    else $error("invalid status outside thin plate spline or with nonzero value");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == ST_ZERO) |-> (y_value_o == '0 && mode_q != MODE_BYPASS))
    else $error("zero status on a nonzero or bypass result");
`endif

endmodule

FILE: tb/radial_basis_function_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the radial basis function unit: directed table, then random phases.
module radial_basis_function_unit_tb;
  import rbf_pkg::*;

  localparam int unsigned LATENCY  = 52;    // accepting edge to valid_o, from the top level
  localparam int unsigned WDOG_MAX = 2000;  // cycles with no request or result taken
  localparam int unsigned PHASES   = 10;
  localparam int unsigned PHASE_N  = 103;   // random requests per phase

  typedef struct packed {
    logic [YW-1:0] y;
    rbf_status_e   st;
  } rbf_out_t;

  // one directed request, with the setting it runs under
  typedef struct {
    rbf_mode_e     mode;
    logic [BW-1:0] beta;
    logic [XW-1:0] x;
    bit            typed;  // expected value typed below, not predicted
    logic [YW-1:0] y;
    rbf_status_e   st;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [XW-1:0]        x_value_i = '0;
  logic                 cfg_we_i = 1'b0;
  logic [0:0]           cfg_index_i = CFG_MODE;
  logic [BW-1:0]        cfg_data_i = '0;
  logic                 valid_o;
  logic signed [YW-1:0] y_value_o;
  logic [1:0]           status_o;

  // expectation riding along with each request, read by the monitor with start
  logic                 req_typed = 1'b0;
  rbf_out_t             req_out = '0;

  rbf_out_t             pending_results[$];
  int unsigned          err_cnt = 0;
  int unsigned          idle_cycles = 0;

  // register copies held by the predictor
  rbf_mode_e            cur_mode = MODE_GAUSS;
  logic [BW-1:0]        cur_beta = 24'h01_0000;

  // setting the stimulus side last wrote (tracks writes, not acceptance)
  rbf_mode_e            drv_mode = MODE_GAUSS;
  logic [BW-1:0]        drv_beta = 24'h01_0000;
  bit                   calm = 1'b0;

  radial_basis_function_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .x_value_i   (x_value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .valid_o     (valid_o),
    .y_value_o   (y_value_o),
    .status_o    (status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // exp(-beta*x*x): cap at 32.0, Horner series of exp(-t/32), then square five times
  function automatic logic [63:0] gauss_q16(logic [23:0] xa, logic [BW-1:0] b);
    logic [127:0] prod;
    logic [63:0]  t;
    logic [63:0]  f;
    logic [63:0]  e;
    logic [127:0] w;
    prod = 128'(xa) * 128'(xa) * 128'(b);
    if ((prod >> 16) >= (128'd1 << 64)) t = 64'd32 << 32;
    else t = prod[79:16];
    if (t >= (64'd32 << 32)) return 64'd0;
    f = t >> 5;
    e = 64'd1 << 32;
    for (int k = 14; k >= 1; k--) begin
      w = (128'(f) * 128'(e)) >> 32;
      e = (64'd1 << 32) - 64'(w / k);
    end
    for (int k = 0; k < 5; k++) begin
      if (e < (64'd1 << 32)) begin
        w = (128'(e) * 128'(e) + 128'h8000_0000) >> 32;
        e = w[63:0];
      end
    end
    return (e + (64'd1 << 15)) >> 16;
  endfunction

  // sqrt(x*x + beta*beta), rounded to nearest
  function automatic logic [63:0] mquad_q16(logic [23:0] xa, logic [BW-1:0] b);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] bit_w;
    n = 64'(xa) * 64'(xa) + 64'(b) * 64'(b);
    r = '0;
    bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (n >= r + bit_w) begin
        n = n - (r + bit_w);
        r = (r >> 1) + bit_w;
      end else begin
        r = r >> 1;
      end
      bit_w = bit_w >> 2;
    end
    if (n > r) r++;
    return r;
  endfunction

  // x*x*ln(x) for x > 0, via a bitwise log2; saturates to the 40-bit range
  function automatic rbf_out_t tps_q16(logic [23:0] x);
    rbf_out_t     res;
    int unsigned  m;
    logic [63:0]  z;
    logic [63:0]  frac;
    longint       l2;
    logic [63:0]  mag;
    logic [63:0]  lnm;
    logic [127:0] prod;
    logic [127:0] q;
    logic [127:0] lim;
    bit           neg;
    bit           rb;
    m = 0;
    while (m < 63 && (64'(x) >> (m + 1)) != 0) m++;
    z = 64'(x) << (30 - m);
    frac = '0;
    for (int i = 1; i <= 30; i++) begin
      z = (z * z) >> 30;
      if (z >= (64'd2 << 30)) begin
        z = z >> 1;
        frac = frac | (64'd1 << (30 - i));
      end
    end
    l2 = (longint'(m) - longint'(FRAC_BITS)) * (longint'(1) << 30) + longint'(frac);
    neg = l2 < 0;
    mag = neg ? 64'(-l2) : 64'(l2);
    lnm = (mag * 64'(LN2_Q28) + (64'd1 << 27)) >> 28;
    prod = 128'(x) * 128'(x) * 128'(lnm);
    q = prod >> (FRAC_BITS + 30);
    rb = prod[FRAC_BITS + 29];
    lim = neg ? 128'(Y_NEG_MAG) : 128'(Y_POS_MAX);
    res.st = ST_OK;
    if (q + rb > lim) begin
      q = lim;
      res.st = ST_SAT;
    end else begin
      q = q + rb;
    end
    res.y = neg ? (YW'(0) - q[YW-1:0]) : q[YW-1:0];
    return res;
  endfunction

  function automatic rbf_out_t rbf_predict(logic [XW-1:0] x, rbf_mode_e md, logic [BW-1:0] b);
    rbf_out_t    res;
    logic [23:0] xa;
    bit          negx;
    negx = x[XW-1];
    xa = negx ? (24'd0 - x) : x;  // the most negative sample keeps magnitude 2^23
    res.y = '0;
    res.st = ST_OK;
    case (md)
      MODE_GAUSS:  res.y = YW'(gauss_q16(xa, b));
      MODE_MQUAD:  res.y = YW'(mquad_q16(xa, b));
      MODE_TPS: begin
        if (negx || x == '0) res.st = ST_INVALID;
        else res = tps_q16(x);
      end
      default:     res.y = {{(YW-XW){x[XW-1]}}, x};
    endcase
    if (md != MODE_BYPASS && res.st == ST_OK && res.y == '0) res.st = ST_ZERO;
    return res;
  endfunction

  // Check results first, then log the request taken at this edge and track writes.
  always @(posedge clk_i) begin
    rbf_out_t exp_out;
    bit       took;
    took = 1'b0;
    if (valid_o) begin
      took = 1'b1;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: y_value %0d status %0d", y_value_o, status_o);
        err_cnt++;
      end else begin
        exp_out = pending_results.pop_front();
        if (y_value_o !== exp_out.y) begin
          $error("y_value: expected %0d, got %0d", $signed(exp_out.y), y_value_o);
          err_cnt++;
        end
        if (status_o !== exp_out.st) begin
          $error("status: expected %0d, got %0d", exp_out.st, status_o);
          err_cnt++;
        end
      end
    end
    if (rst_ni && start && !busy) begin
      took = 1'b1;
      pending_results.push_back(req_typed ? req_out
                                          : rbf_predict(x_value_i, cur_mode, cur_beta));
    end
    if (rst_ni && cfg_we_i) begin
      if (cfg_index_i == CFG_MODE) cur_mode = rbf_mode_e'(cfg_data_i[1:0]);
      else cur_beta = cfg_data_i;
    end
    idle_cycles = took ? 0 : idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("FAIL");
      $finish;
    end
  end

  // Hold off until every request in flight has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Drain, then write both registers; mode carries junk in the unused upper bits.
  task automatic set_regs(rbf_mode_e md, logic [BW-1:0] b);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_MODE;
    cfg_data_i  <= {(BW-2)'($urandom), md};
    @(posedge clk_i);
    cfg_index_i <= CFG_BETA;
    cfg_data_i  <= b;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    drv_mode = md;
    drv_beta = b;
  endtask

  // Present one request and advance until it is taken; maybe idle afterward.
  task automatic send(logic [XW-1:0] x, bit typed, rbf_out_t exp_out);
    int unsigned gap;
    start     <= 1'b1;
    x_value_i <= x;
    req_typed <= typed;
    req_out   <= exp_out;
    do @(posedge clk_i); while (busy);
    if (!calm && $urandom_range(5) == 0) begin
      gap = $urandom_range(1, 7);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Pick a sample: mostly small magnitudes, where the kernels do interesting work.
  function automatic logic [XW-1:0] pick_x();
    case ($urandom_range(5))
      0, 1: return XW'($urandom);
      2:    return XW'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      3:    return XW'($signed($urandom_range(0, 511)) - 256);
      4:    return $urandom_range(1) ? 24'h80_0000 : 24'h7F_FFFF;
      default: return XW'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic logic [BW-1:0] pick_beta();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      2:       return 24'h01_0000;
      3:       return BW'($urandom_range(0, 24'h04_0000));
      default: return BW'($urandom);
    endcase
  endfunction

  initial begin
    dir_row_t  dir_rows[$];
    rbf_mode_e md;
    rbf_out_t  none;
    none = '0;
    // reset values first, then extremes of every kernel and the special cases
    dir_rows = '{
      '{MODE_GAUSS,  24'h01_0000, 24'h00_0000, 1, 40'd65536,   ST_OK},
      '{MODE_GAUSS,  24'h01_0000, 24'h7F_FFFF, 1, 40'd0,       ST_ZERO},
      '{MODE_GAUSS,  24'h01_0000, 24'h80_0000, 1, 40'd0,       ST_ZERO},
      '{MODE_GAUSS,  24'h01_0000, 24'h01_0000, 0, 40'd0,       ST_OK},
      '{MODE_GAUSS,  24'h01_0000, 24'hFF_8000, 0, 40'd0,       ST_OK},
      '{MODE_GAUSS,  24'h00_0000, 24'h12_3456, 1, 40'd65536,   ST_OK},
      '{MODE_GAUSS,  24'hFF_FFFF, 24'h00_0001, 0, 40'd0,       ST_OK},
      '{MODE_MQUAD,  24'h00_0000, 24'h00_0000, 1, 40'd0,       ST_ZERO},
      '{MODE_MQUAD,  24'h00_0000, 24'h7F_FFFF, 0, 40'd0,       ST_OK},
      '{MODE_MQUAD,  24'h01_0000, 24'h00_0000, 1, 40'd65536,   ST_OK},
      '{MODE_MQUAD,  24'hFF_FFFF, 24'h80_0000, 0, 40'd0,       ST_OK},
      '{MODE_MQUAD,  24'hFF_FFFF, 24'hFF_FFFF, 0, 40'd0,       ST_OK},
      '{MODE_TPS,    24'h01_0000, 24'h00_0000, 1, 40'd0,       ST_INVALID},
      '{MODE_TPS,    24'h01_0000, 24'hFF_FFFF, 1, 40'd0,       ST_INVALID},
      '{MODE_TPS,    24'h01_0000, 24'h80_0000, 1, 40'd0,       ST_INVALID},
      '{MODE_TPS,    24'h01_0000, 24'h01_0000, 1, 40'd0,       ST_ZERO},
      '{MODE_TPS,    24'h01_0000, 24'h00_0001, 0, 40'd0,       ST_OK},
      '{MODE_TPS,    24'h01_0000, 24'h00_8000, 0, 40'd0,       ST_OK},
      '{MODE_TPS,    24'h01_0000, 24'h7F_FFFF, 0, 40'd0,       ST_OK},
      '{MODE_BYPASS, 24'h01_0000, 24'h7F_FFFF, 1, 40'd8388607, ST_OK},
      '{MODE_BYPASS, 24'h01_0000, 24'h80_0000, 1, -40'sd8388608, ST_OK},
      '{MODE_BYPASS, 24'h01_0000, 24'h00_0000, 1, 40'd0,       ST_OK},
      '{MODE_BYPASS, 24'h01_0000, 24'hFF_FFFF, 1, -40'sd1,     ST_OK}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; reset values serve the first rows, so no write until the mode or beta moves
    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != drv_mode || dir_rows[i].beta != drv_beta)
        set_regs(dir_rows[i].mode, dir_rows[i].beta);
      send(dir_rows[i].x, dir_rows[i].typed, '{dir_rows[i].y, dir_rows[i].st});
    end

    // random phases; each write waits for a drain, so the sender pauses every phase
    for (int p = 0; p < PHASES; p++) begin
      md = (p < 4) ? rbf_mode_e'(p) : rbf_mode_e'($urandom_range(3));
      set_regs(md, (p == 0) ? '1 : (p == 1) ? '0 : pick_beta());
      calm = (p >= PHASES - 2);
      for (int n = 0; n < PHASE_N; n++) send(pick_x(), 1'b0, none);
    end

    drain();
    repeat (LATENCY + 8) @(posedge clk_i);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rbf_pkg.sv
rtl/rbf_gauss.sv
rtl/rbf_mquad.sv
rtl/rbf_tps.sv
rtl/radial_basis_function_unit.sv
tb/radial_basis_function_unit_tb.sv
